/* src/jddm_pkg.sv */
// Shared types, constants and helper functions for the joystick drive mixer.
package jddm_pkg;

    localparam int ADC_W   = 12;
    localparam int FRAC_W  = 8;
    localparam int FILT_W  = ADC_W + FRAC_W;
    localparam int PULSE_W = 11;
    localparam int MODE_W  = 4;
    localparam int PCT_W   = 7;
    localparam int SUM_W   = FILT_W + 8;
    localparam int PCTX_W  = ADC_W + 7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int ADDR_W     = 5;

    typedef logic [ADC_W-1:0]   t_adc;
    typedef logic [FILT_W-1:0]  t_filt;
    typedef logic [PULSE_W-1:0] t_pulse;
    typedef logic [PCT_W-1:0]   t_pct;

    localparam t_adc   ADC_MAX   = t_adc'((1 << ADC_W) - 1);
    localparam t_adc   ADC_HALF  = t_adc'(1 << (ADC_W - 1));
    localparam t_filt  FILT_INIT = t_filt'(ADC_HALF) << FRAC_W;

    localparam logic [7:0] ALPHA_NUM  = 8'd77;
    localparam logic [7:0] ALPHA_REST = 8'd179;

    localparam t_pulse NEUTRAL_US   = 11'd1500;
    localparam t_pulse SPIN_SLOW_US = 11'd1250;
    localparam t_pulse SPIN_FAST_US = 11'd1750;

    // floor(v / 5) for v below 2^13, as a multiply by 3277 / 2^14
    localparam logic [11:0] RECIP5 = 12'd3277;

    typedef enum logic [2:0] {
        REG_X_MIN    = 3'd0,
        REG_X_MAX    = 3'd1,
        REG_X_CENTER = 3'd2,
        REG_Y_MIN    = 3'd3,
        REG_Y_MAX    = 3'd4,
        REG_Y_CENTER = 3'd5
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEUTRAL    = 4'd0,
        MODE_FWD        = 4'd1,
        MODE_FWD_LEFT   = 4'd2,
        MODE_FWD_RIGHT  = 4'd3,
        MODE_BACK       = 4'd4,
        MODE_BACK_LEFT  = 4'd5,
        MODE_BACK_RIGHT = 4'd6,
        MODE_SPIN_LEFT  = 4'd7,
        MODE_SPIN_RIGHT = 4'd8
    } t_mode;

    function automatic t_adc div5(input logic [ADC_W:0] v);
        logic [ADC_W+12:0] prod;
        prod = (ADC_W+13)'(v) * (ADC_W+13)'(RECIP5);
        return t_adc'(prod >> 14);
    endfunction

    // center - ceil(span / 5), span taken as zero when min lies above center
    function automatic t_adc thr_low(input t_adc center, input t_adc lo);
        logic [ADC_W:0] d;
        d = (lo > center) ? '0 : {1'b0, center - lo};
        return center - div5(d + (ADC_W+1)'(4));
    endfunction

    // center + floor(span / 5), span taken as zero when max lies below center
    function automatic t_adc thr_high(input t_adc center, input t_adc hi);
        logic [ADC_W:0] d;
        d = (hi < center) ? '0 : {1'b0, hi - center};
        return center + div5(d);
    endfunction

endpackage

/* src/jddm_lowpass.sv */
// First-order low-pass update, alpha 77/256, on one fixed-point channel.
module jddm_lowpass (
    input  jddm_pkg::t_filt i_filt,
    input  jddm_pkg::t_adc  i_sample,
    output jddm_pkg::t_filt o_filt
);
    import jddm_pkg::*;

    logic [SUM_W-1:0] w_new_part;
    logic [SUM_W-1:0] w_old_part;
    logic [SUM_W-1:0] w_sum;

    assign w_new_part = SUM_W'({i_sample, {FRAC_W{1'b0}}}) * SUM_W'(ALPHA_NUM);
    assign w_old_part = SUM_W'(i_filt) * SUM_W'(ALPHA_REST);
    assign w_sum      = w_new_part + w_old_part;

    // drop the 1/256 of the weights, truncating
    assign o_filt = w_sum[SUM_W-1:8];

endmodule

/* src/joystick_differential_drive_mixer.sv */
// Top level of the joystick differential drive mixer: config, filter stage, decision stage.
//
// Takes one transaction of raw X, Y and speed-pot samples per clock and returns one
// result transaction with both servo pulses, the motion mode and the speed percent.
// A sample is accepted in every cycle while the output side keeps up. The filter and
// threshold registers take the sample at acceptance, the result register takes the
// decision when the filter stage advances. Throughput is one transaction per cycle
// while the output keeps up. Input ready follows output ready combinationally once both
// stages are full, so a stalled output holds at most one further sample in the filter
// stage before the input side stalls. Calibration registers are to be written through
// the APB port only while no transaction is in flight; the block does not enforce it.
// A new center does not reload the filters, which start at mid-scale after reset.
module joystick_differential_drive_mixer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [11:0] stick_x_sample, [23:12] stick_y_sample, [35:24] speed_pot_sample
    input  logic [jddm_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] left_pulse_us, [21:11] right_pulse_us, [25:22] motion_mode,
    // [32:26] throttle_pct
    output logic [jddm_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jddm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import jddm_pkg::*;

    // calibration registers
    t_adc r_x_min, r_x_max, r_x_center;
    t_adc r_y_min, r_y_max, r_y_center;

    // filter stage
    logic  r_s1_valid;
    t_filt r_filt_x, r_filt_y, r_filt_spd;
    t_adc  r_lx, r_hx, r_ly, r_hy;

    // result stage
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic     w_cfg_wr;
    t_reg_idx w_idx;
    t_adc     w_wval;
    logic     w_accept;
    logic     w_advance;
    t_adc     w_in_x, w_in_y, w_in_spd;
    t_filt    n_filt_x, n_filt_y, n_filt_spd;

    logic [PCTX_W-1:0] w_pct_x;
    logic [PCT_W-1:0]  w_pct_q0;
    logic [ADC_W:0]    w_pct_rem;
    t_pct              w_pct;
    logic [8:0]        w_full;
    logic [7:0]        w_part;
    logic              w_xl, w_xh, w_yl, w_yh;
    t_mode             w_mode;
    t_pulse            w_left, w_right;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wval   = pwdata[ADC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min    <= '0;
            r_x_max    <= ADC_MAX;
            r_x_center <= ADC_HALF;
            r_y_min    <= '0;
            r_y_max    <= ADC_MAX;
            r_y_center <= ADC_HALF;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_X_MIN:    r_x_min    <= w_wval;
                REG_X_MAX:    r_x_max    <= w_wval;
                REG_X_CENTER: r_x_center <= w_wval;
                REG_Y_MIN:    r_y_min    <= w_wval;
                REG_Y_MAX:    r_y_max    <= w_wval;
                REG_Y_CENTER: r_y_center <= w_wval;
                default:      ; // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_MIN:    prdata = 32'(r_x_min);
            REG_X_MAX:    prdata = 32'(r_x_max);
            REG_X_CENTER: prdata = 32'(r_x_center);
            REG_Y_MIN:    prdata = 32'(r_y_min);
            REG_Y_MAX:    prdata = 32'(r_y_max);
            REG_Y_CENTER: prdata = 32'(r_y_center);
            default:      prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // advance the filter stage into the result register when that is free or draining
    assign w_advance       = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- filter stage ----------------
    assign w_in_x   = i_s_axis_tdata[ADC_W-1:0];
    assign w_in_y   = i_s_axis_tdata[2*ADC_W-1:ADC_W];
    assign w_in_spd = i_s_axis_tdata[3*ADC_W-1:2*ADC_W];

    jddm_lowpass u_lp_x (.i_filt(r_filt_x),   .i_sample(w_in_x),   .o_filt(n_filt_x));
    jddm_lowpass u_lp_y (.i_filt(r_filt_y),   .i_sample(w_in_y),   .o_filt(n_filt_y));
    jddm_lowpass u_lp_s (.i_filt(r_filt_spd), .i_sample(w_in_spd), .o_filt(n_filt_spd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_filt_x   <= FILT_INIT;
            r_filt_y   <= FILT_INIT;
            r_filt_spd <= FILT_INIT;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_filt_x   <= n_filt_x;
                r_filt_y   <= n_filt_y;
                r_filt_spd <= n_filt_spd;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // deadband thresholds travel with the sample, taken from calibration at acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lx <= thr_low(r_x_center, r_x_min);
            r_hx <= thr_high(r_x_center, r_x_max);
            r_ly <= thr_low(r_y_center, r_y_min);
            r_hy <= thr_high(r_y_center, r_y_max);
        end
    end

    // ---------------- decision stage ----------------
    // pct = floor(u * 100 / 4095): divide by 4096, then fold the quotient back into
    // the remainder since 4095 = 4096 - 1; one correction step suffices
    always_comb begin
        w_pct_x   = PCTX_W'({r_filt_spd[FILT_W-1:FRAC_W], 6'b0})
                  + PCTX_W'({r_filt_spd[FILT_W-1:FRAC_W], 5'b0})
                  + PCTX_W'({r_filt_spd[FILT_W-1:FRAC_W], 2'b0});
        w_pct_q0  = w_pct_x[PCTX_W-1:ADC_W];
        w_pct_rem = (ADC_W+1)'(w_pct_x[ADC_W-1:0]) + (ADC_W+1)'(w_pct_q0);
        w_pct     = (w_pct_rem >= (ADC_W+1)'(ADC_MAX)) ? w_pct_q0 + 7'd1 : w_pct_q0;
        w_full    = 9'({w_pct, 2'b0}) + 9'(w_pct);
        w_part    = {w_pct, 1'b0};
    end

    assign w_xl = r_filt_x < {r_lx, {FRAC_W{1'b0}}};
    assign w_xh = r_filt_x > {r_hx, {FRAC_W{1'b0}}};
    assign w_yl = r_filt_y < {r_ly, {FRAC_W{1'b0}}};
    assign w_yh = r_filt_y > {r_hy, {FRAC_W{1'b0}}};

    always_comb begin
        w_mode  = MODE_NEUTRAL;
        w_left  = NEUTRAL_US;
        w_right = NEUTRAL_US;
        if (w_yl) begin
            if (w_xl) begin
                w_mode  = MODE_FWD_LEFT;
                w_left  = NEUTRAL_US + PULSE_W'(w_part);
                w_right = NEUTRAL_US + PULSE_W'(w_full);
            end else if (w_xh) begin
                w_mode  = MODE_FWD_RIGHT;
                w_left  = NEUTRAL_US + PULSE_W'(w_full);
                w_right = NEUTRAL_US + PULSE_W'(w_part);
            end else begin
                w_mode  = MODE_FWD;
                w_left  = NEUTRAL_US + PULSE_W'(w_full);
                w_right = NEUTRAL_US + PULSE_W'(w_full);
            end
        end else if (w_yh) begin
            if (w_xl) begin
                w_mode  = MODE_BACK_LEFT;
                w_left  = NEUTRAL_US - PULSE_W'(w_part);
                w_right = NEUTRAL_US - PULSE_W'(w_full);
            end else if (w_xh) begin
                w_mode  = MODE_BACK_RIGHT;
                w_left  = NEUTRAL_US - PULSE_W'(w_full);
                w_right = NEUTRAL_US - PULSE_W'(w_part);
            end else begin
                w_mode  = MODE_BACK;
                w_left  = NEUTRAL_US - PULSE_W'(w_full);
                w_right = NEUTRAL_US - PULSE_W'(w_full);
            end
        end else if (w_xl) begin
            w_mode  = MODE_SPIN_LEFT;
            w_left  = SPIN_SLOW_US;
            w_right = SPIN_FAST_US;
        end else if (w_xh) begin
            w_mode  = MODE_SPIN_RIGHT;
            w_left  = SPIN_FAST_US;
            w_right = SPIN_SLOW_US;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OUT_DATA_W'({w_pct, w_mode, w_right, w_left});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // neutral mode always carries centred pulses
    a_neutral_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[25:22] == MODE_NEUTRAL) |->
        (r_out_data[10:0] == NEUTRAL_US && r_out_data[21:11] == NEUTRAL_US))
        else $error("neutral result with off-centre pulses");

    // speed percent never exceeds full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[32:26] <= 7'd100))
        else $error("speed percent above 100");

    // spin-left mode uses the fixed slow and fast pulses
    a_spin_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[25:22] == MODE_SPIN_LEFT) |->
        (r_out_data[10:0] == SPIN_SLOW_US && r_out_data[21:11] == SPIN_FAST_US))
        else $error("spin-left result with wrong pulses");

    // a sample held behind a stalled result is neither lost nor duplicated
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |=>
        (r_s1_valid && r_out_valid))
        else $error("filter stage dropped while output stalled");

    // the input side stalls only when the filter stage is occupied
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without cause");
`endif

endmodule

/* dv/tb_joystick_differential_drive_mixer.sv */
// Self-checking testbench for the joystick differential drive mixer.
module tb_joystick_differential_drive_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import jddm_pkg::*;

    localparam int          CLK_HALF_NS   = 10;
    localparam int          IDLE_PCT      = 7;    // chance in a hundred of a gap or stall
    localparam int          SETTLE_CYCLES = 4;    // result register plus filter stage, with margin
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          MAX_REPORTS   = 10;
    localparam realtime     TIMEOUT_NS    = 4_000_000;
    // paddr 5 bits wide leaves two word addresses with no register behind them
    localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
    localparam int unsigned FILTER_TAKE   = 77;   // weight of the new sample, out of 256
    localparam int unsigned FILTER_KEEP   = 179;  // weight of the held value, out of 256
    localparam int unsigned FULL_SCALE    = 4095;
    localparam t_adc        ADC_TOP       = 12'd4095;
    localparam t_pulse      PULSE_MID     = 11'd1500;
    localparam t_pulse      PULSE_SLOW    = 11'd1250;
    localparam t_pulse      PULSE_FAST    = 11'd1750;

    typedef struct {
        t_pulse left;
        t_pulse right;
        t_mode  mode;
        t_pct   pct;
    } t_drive;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    // [11:0] stick_x_sample, [23:12] stick_y_sample, [35:24] speed_pot_sample
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    // [10:0] left_pulse_us, [21:11] right_pulse_us, [25:22] motion_mode,
    // [32:26] throttle_pct
    logic [OUT_DATA_W-1:0] m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Mirror of the calibration registers and the three filters
    t_adc   cal [6];
    t_filt  filt_x;
    t_filt  filt_y;
    t_filt  filt_spd;

    t_drive drive_q [$];      // drive results still owed by the block, oldest first
    t_mode  last_mode;
    bit     no_gaps;
    int     samples_sent;
    int     results_seen;
    int     mismatches;
    int     settings_used;
    bit [8:0] modes_hit;

    joystick_differential_drive_mixer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_HALF_NS);
        i_clk = 1'b1;
        #(CLK_HALF_NS);
    end

    // Stall the result side now and then, never while a back-to-back stretch runs
    always @(posedge i_clk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    //------------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------------

    // One step of the alpha = 77/256 low-pass, 12.8 fixed point, truncated
    function automatic t_filt smooth(input t_filt f, input t_adc s);
        logic [31:0] acc;
        acc = FILTER_TAKE * 32'({s, {FRAC_W{1'b0}}}) + FILTER_KEEP * 32'(f);
        return t_filt'(acc >> 8);
    endfunction

    // Lower deadband edge: a fifth of the span below centre, rounded outwards;
    // a minimum above the centre leaves no span at all
    function automatic t_adc deadband_low(input t_adc centre, input t_adc lo);
        int d;
        d = (lo > centre) ? 0 : int'(centre) - int'(lo);
        return t_adc'(int'(centre) - (d + 4) / 5);
    endfunction

    function automatic t_adc deadband_high(input t_adc centre, input t_adc hi);
        int d;
        d = (hi < centre) ? 0 : int'(hi) - int'(centre);
        return t_adc'(int'(centre) + d / 5);
    endfunction

    // Advance the filters by one tick and work out the mixer decision
    function automatic t_drive predict_drive(input t_adc x, input t_adc y, input t_adc p);
        t_drive      r;
        int unsigned pct_v;
        t_filt       lx, hx, ly, hy;
        logic        xl, xh;
        t_pulse      full, part;

        filt_x   = smooth(filt_x, x);
        filt_y   = smooth(filt_y, y);
        filt_spd = smooth(filt_spd, p);

        pct_v = 32'(filt_spd >> FRAC_W) * 100 / FULL_SCALE;
        if (pct_v > 100) begin
            pct_v = 100;
        end
        full = t_pulse'(5 * pct_v);
        part = t_pulse'(2 * pct_v);

        lx = {deadband_low(cal[REG_X_CENTER], cal[REG_X_MIN]), {FRAC_W{1'b0}}};
        hx = {deadband_high(cal[REG_X_CENTER], cal[REG_X_MAX]), {FRAC_W{1'b0}}};
        ly = {deadband_low(cal[REG_Y_CENTER], cal[REG_Y_MIN]), {FRAC_W{1'b0}}};
        hy = {deadband_high(cal[REG_Y_CENTER], cal[REG_Y_MAX]), {FRAC_W{1'b0}}};
        xl = filt_x < lx;
        xh = filt_x > hx;

        r.pct   = t_pct'(pct_v);
        r.mode  = MODE_NEUTRAL;
        r.left  = PULSE_MID;
        r.right = PULSE_MID;
        // Low Y is forward; the X deadband then picks straight, left or right
        if (filt_y < ly) begin
            if (xl) begin
                r.mode = MODE_FWD_LEFT;  r.left = PULSE_MID + part; r.right = PULSE_MID + full;
            end else if (xh) begin
                r.mode = MODE_FWD_RIGHT; r.left = PULSE_MID + full; r.right = PULSE_MID + part;
            end else begin
                r.mode = MODE_FWD;       r.left = PULSE_MID + full; r.right = PULSE_MID + full;
            end
        end else if (filt_y > hy) begin
            if (xl) begin
                r.mode = MODE_BACK_LEFT;  r.left = PULSE_MID - part; r.right = PULSE_MID - full;
            end else if (xh) begin
                r.mode = MODE_BACK_RIGHT; r.left = PULSE_MID - full; r.right = PULSE_MID - part;
            end else begin
                r.mode = MODE_BACK;       r.left = PULSE_MID - full; r.right = PULSE_MID - full;
            end
        end else if (xl) begin
            // spin speeds are fixed, the pot has no say
            r.mode = MODE_SPIN_LEFT;  r.left = PULSE_SLOW; r.right = PULSE_FAST;
        end else if (xh) begin
            r.mode = MODE_SPIN_RIGHT; r.left = PULSE_FAST; r.right = PULSE_SLOW;
        end
        return r;
    endfunction

    //------------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------------

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
            end
        end
    endtask

    // Sample at the falling edge: a transaction seen here completes at the next rising edge,
    // and nothing on the bus moves in between
    always @(negedge i_clk) begin : result_check
        t_drive want;
        if (i_rst_n && m_valid === 1'b1 && m_ready) begin
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] drive result with none outstanding: %h", $realtime, m_data);
                end
            end else begin
                want = drive_q.pop_front();
                check_field("left_pulse_us",  want.left,  m_data[10:0]);
                check_field("right_pulse_us", want.right, m_data[21:11]);
                check_field("motion_mode",    want.mode,  m_data[25:22]);
                check_field("throttle_pct",   want.pct,   m_data[32:26]);
                check_field("tdata padding",  '0,         m_data[OUT_DATA_W-1:33]);
                modes_hit[want.mode] = 1'b1;
                results_seen++;
            end
        end
    end

    //------------------------------------------------------------------------
    // Bus drivers
    //------------------------------------------------------------------------

    // Offer one tick of samples, hold it until taken, then log what it should produce
    task automatic send_sample(input t_adc x, input t_adc y, input t_adc p);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(IN_DATA_W - 3 * ADC_W){1'b0}}, p, y, x};
        @(negedge i_clk);
        while (!s_ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        drive_q.push_back(predict_drive(x, y, p));
        last_mode = drive_q[$].mode;
        samples_sent++;
    endtask

    // Drop valid and wait for every owed result, then let the pipeline empty out
    task automatic wait_drained();
        s_valid <= 1'b0;
        for (int guard = 0; guard < DRAIN_LIMIT && drive_q.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access, then idle, so that back-to-back calls never
    // assign the same bus signal twice in one step
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_Y_CENTER) begin
            cal[idx] = t_adc'(value);
        end
        @(posedge i_clk);
    endtask

    task automatic check_register(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        check_field("register readback", 32'(cal[idx]), prdata);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all six calibration registers, with junk above bit 11, then read them back
    task automatic program_calibration(input t_adc setting [6]);
        wait_drained();
        for (int i = 0; i < 6; i++) begin
            apb_write(3'(i), {20'($urandom), setting[i]});
        end
        for (int i = 0; i < 6; i++) begin
            check_register(t_reg_idx'(i));
        end
        settings_used++;
    endtask

    //------------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------------

    // Aim a channel at a level that tends to sit on or across the deadband edges
    function automatic t_adc pick_level(input t_adc lo, input t_adc mid, input t_adc hi);
        case ($urandom_range(6))
            0:       return '0;
            1:       return ADC_TOP;
            2:       return lo;
            3:       return hi;
            4:       return mid;
            default: return t_adc'($urandom_range(FULL_SCALE));
        endcase
    endfunction

    // Half the time hold the level exactly, else shake it by a few counts
    function automatic t_adc wobble(input t_adc v);
        int w;
        if ($urandom_range(1) == 0) begin
            return v;
        end
        w = int'(v) + int'($urandom_range(8)) - 4;
        return t_adc'((w < 0) ? 0 : (w > int'(FULL_SCALE)) ? FULL_SCALE : w);
    endfunction

    // Mostly held stick positions with small noise, as a driver would produce;
    // now and then a long hold to pin a filter at full scale, and some bare noise
    task automatic run_joystick(input int count);
        t_adc tx, ty, tp;
        int   hold;
        while (count > 0) begin
            tx   = pick_level(cal[REG_X_MIN], cal[REG_X_CENTER], cal[REG_X_MAX]);
            ty   = pick_level(cal[REG_Y_MIN], cal[REG_Y_CENTER], cal[REG_Y_MAX]);
            tp   = pick_level('0, ADC_HALF, ADC_TOP);
            hold = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
            while (hold > 0 && count > 0) begin
                if ($urandom_range(99) < 15) begin
                    send_sample(t_adc'($urandom), t_adc'($urandom), t_adc'($urandom));
                end else begin
                    send_sample(wobble(tx), wobble(ty), wobble(tp));
                end
                hold--;
                count--;
            end
        end
    endtask

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    task automatic test_reset_registers();
        for (int i = 0; i < 6; i++) begin
            check_register(t_reg_idx'(i));
        end
    endtask

    // Steer the stick into each of the nine moves in turn; one axis changes at a time,
    // and the pot swings between its ends from one move to the next
    task automatic test_every_mode();
        t_mode order [9] = '{MODE_NEUTRAL, MODE_FWD, MODE_FWD_LEFT, MODE_SPIN_LEFT,
                             MODE_BACK_LEFT, MODE_BACK, MODE_BACK_RIGHT, MODE_SPIN_RIGHT,
                             MODE_FWD_RIGHT};
        t_adc  x, y;
        int    tries;
        for (int i = 0; i < 9; i++) begin
            x = cal[REG_X_CENTER];
            y = cal[REG_Y_CENTER];
            case (order[i])
                MODE_FWD:        y = '0;
                MODE_FWD_LEFT:   begin x = '0;      y = '0;      end
                MODE_FWD_RIGHT:  begin x = ADC_TOP; y = '0;      end
                MODE_BACK:       y = ADC_TOP;
                MODE_BACK_LEFT:  begin x = '0;      y = ADC_TOP; end
                MODE_BACK_RIGHT: begin x = ADC_TOP; y = ADC_TOP; end
                MODE_SPIN_LEFT:  x = '0;
                MODE_SPIN_RIGHT: x = ADC_TOP;
                default:         ;
            endcase
            tries = 0;
            do begin
                send_sample(x, y, (i % 2 == 1) ? ADC_TOP : '0);
                tries++;
            end while (last_mode != order[i] && tries < 6);
        end
        wait_drained();
    endtask

    // Centres at the rails, inverted spans, a zero-width deadband, and writes to the
    // two spare addresses, which must leave every register alone
    task automatic test_calibration_corners();
        t_adc corners [5][6] = '{
            '{12'd0,    12'd4095, 12'd0,    12'd0,    12'd4095, 12'd4095},
            '{12'd0,    12'd4095, 12'd4095, 12'd0,    12'd4095, 12'd0},
            '{12'd3000, 12'd1000, 12'd2000, 12'd4095, 12'd0,    12'd2048},
            '{12'd2048, 12'd2048, 12'd2048, 12'd4095, 12'd4095, 12'd4095},
            '{12'd1000, 12'd3000, 12'd2000, 12'd500,  12'd3500, 12'd1200}
        };
        for (int i = 0; i < 5; i++) begin
            program_calibration(corners[i]);
            run_joystick(40);
        end
        wait_drained();
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        for (int i = 0; i < 6; i++) begin
            check_register(t_reg_idx'(i));
        end
        run_joystick(20);
    endtask

    // Random calibrations: mostly min <= centre <= max, sometimes with the ends swapped
    task automatic test_random_calibration();
        t_adc setting [6];
        t_adc lo, hi;
        for (int n = 0; n < 3; n++) begin
            for (int a = 0; a < 2; a++) begin
                setting[3*a + 2] = t_adc'($urandom_range(FULL_SCALE));
                lo = t_adc'($urandom_range(setting[3*a + 2]));
                hi = t_adc'($urandom_range(FULL_SCALE, setting[3*a + 2]));
                if ($urandom_range(3) == 0) begin
                    setting[3*a]     = hi;
                    setting[3*a + 1] = lo;
                end else begin
                    setting[3*a]     = lo;
                    setting[3*a + 1] = hi;
                end
            end
            program_calibration(setting);
            run_joystick(100);
        end
    endtask

    // Hold both sides open so that a transaction moves on every clock
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        run_joystick(80);
        no_gaps = 1'b0;
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------

    initial begin
        cal           = '{12'd0, 12'd4095, 12'd2048, 12'd0, 12'd4095, 12'd2048};
        filt_x        = {cal[REG_X_CENTER], {FRAC_W{1'b0}}};
        filt_y        = {cal[REG_Y_CENTER], {FRAC_W{1'b0}}};
        filt_spd      = {ADC_HALF, {FRAC_W{1'b0}}};
        last_mode     = MODE_NEUTRAL;
        no_gaps       = 1'b0;
        samples_sent  = 0;
        results_seen  = 0;
        mismatches    = 0;
        settings_used = 1;
        modes_hit     = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_every_mode();
        test_calibration_corners();
        test_random_calibration();
        test_back_to_back();

        wait_drained();
        if (drive_q.size() != 0) begin
            $display("%0d drive results never arrived", drive_q.size());
            mismatches += drive_q.size();
        end

        $display("Ran %0d stick samples, checked %0d drive results under %0d calibrations,",
                 samples_sent, results_seen, settings_used);
        $display("reaching %0d of 9 motion modes; %0d mismatches.",
                 $countones(modes_hit), mismatches);
        if (mismatches == 0) begin
            $display("PASS joystick_differential_drive_mixer");
        end else begin
            $display("FAIL joystick_differential_drive_mixer");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d drive results outstanding", drive_q.size());
        $display("FAIL joystick_differential_drive_mixer");
        $finish;
    end

endmodule
